// ----- design/cmf_pkg.sv -----
`timescale 1ns / 1ps

package cmf_pkg;

   // face codes
   localparam logic [2:0] FACE_POS_X = 3'd0;
   localparam logic [2:0] FACE_NEG_X = 3'd1;
   localparam logic [2:0] FACE_POS_Y = 3'd2;
   localparam logic [2:0] FACE_NEG_Y = 3'd3;
   localparam logic [2:0] FACE_POS_Z = 3'd4;
   localparam logic [2:0] FACE_NEG_Z = 3'd5;

   localparam int FACE_COUNT = 6;

   // sideband that travels with each request down the pipe
   typedef struct packed {
      logic       valid;
      logic [2:0] face;
      logic       zero;   // all three components zero
   } cmf_ctl_type;

endpackage

// ----- design/cmf_face_sel.sv -----
`timescale 1ns / 1ps

module cmf_face_sel #(
   parameter int DIR_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        up_valid,
   input  logic signed [DIR_BITS-1:0]  up_dir_x,
   input  logic signed [DIR_BITS-1:0]  up_dir_y,
   input  logic signed [DIR_BITS-1:0]  up_dir_z,
   output cmf_pkg::cmf_ctl_type        dn_ctl,
   output logic [DIR_BITS:0]           dn_denom,
   output logic [DIR_BITS:0]           dn_num_u,
   output logic [DIR_BITS:0]           dn_num_v,
   output logic                        dn_sat_u,
   output logic                        dn_sat_v
);
   import cmf_pkg::*;

   // stage A: capture and magnitudes
   logic                       valid_a_ff;
   logic signed [DIR_BITS-1:0] x_a_ff, y_a_ff, z_a_ff;
   logic [DIR_BITS-1:0]        ax_a_ff, ay_a_ff, az_a_ff;
   logic [DIR_BITS-1:0]        ax_a_in, ay_a_in, az_a_in;

   // stage B: axis choice
   logic                       valid_b_ff;
   logic [2:0]                 face_b_ff, face_b_in;
   logic [DIR_BITS-1:0]        m_b_ff, m_b_in;
   logic signed [DIR_BITS:0]   nu_b_ff, nu_b_in, nv_b_ff, nv_b_in;

   // stage C: numerators and divisor
   cmf_ctl_type                ctl_c_ff, ctl_c_in;
   logic [DIR_BITS:0]          denom_c_ff, denom_c_in;
   logic [DIR_BITS:0]          num_u_c_ff, num_u_c_in, num_v_c_ff, num_v_c_in;
   logic                       sat_u_c_ff, sat_u_c_in, sat_v_c_ff, sat_v_c_in;

   logic signed [DIR_BITS:0]   xe, ye, ze;
   logic                       sel_x, sel_y;
   logic signed [DIR_BITS+1:0] sum_u, sum_v;

   // magnitudes; the most negative value maps to 2^(DIR_BITS-1) unsigned
   always_comb begin
      ax_a_in = up_dir_x[DIR_BITS-1] ? (~up_dir_x + 1'b1) : up_dir_x;
      ay_a_in = up_dir_y[DIR_BITS-1] ? (~up_dir_y + 1'b1) : up_dir_y;
      az_a_in = up_dir_z[DIR_BITS-1] ? (~up_dir_z + 1'b1) : up_dir_z;
   end

   // largest magnitude wins, ties go x, then y
   always_comb begin
      xe    = {x_a_ff[DIR_BITS-1], x_a_ff};
      ye    = {y_a_ff[DIR_BITS-1], y_a_ff};
      ze    = {z_a_ff[DIR_BITS-1], z_a_ff};
      sel_x = (ax_a_ff >= ay_a_ff) && (ax_a_ff >= az_a_ff);
      sel_y = !sel_x && (ay_a_ff >= az_a_ff);
      if (sel_x) begin
         face_b_in = x_a_ff[DIR_BITS-1] ? FACE_NEG_X : FACE_POS_X;
         m_b_in    = ax_a_ff;
         nu_b_in   = -ze;
         nv_b_in   = ye;
      end else if (sel_y) begin
         face_b_in = y_a_ff[DIR_BITS-1] ? FACE_NEG_Y : FACE_POS_Y;
         m_b_in    = ay_a_ff;
         nu_b_in   = xe;
         nv_b_in   = -ze;
      end else begin
         face_b_in = z_a_ff[DIR_BITS-1] ? FACE_NEG_Z : FACE_POS_Z;
         m_b_in    = az_a_ff;
         nu_b_in   = xe;
         nv_b_in   = ye;
      end
   end

   // n + m lies in [0, 2m]; equal to 2m means the code saturates
   always_comb begin
      sum_u          = {nu_b_ff[DIR_BITS], nu_b_ff} + $signed({2'b00, m_b_ff});
      sum_v          = {nv_b_ff[DIR_BITS], nv_b_ff} + $signed({2'b00, m_b_ff});
      num_u_c_in     = sum_u[DIR_BITS:0];
      num_v_c_in     = sum_v[DIR_BITS:0];
      denom_c_in     = {m_b_ff, 1'b0};
      sat_u_c_in     = (num_u_c_in == denom_c_in);
      sat_v_c_in     = (num_v_c_in == denom_c_in);
      ctl_c_in.valid = valid_b_ff;
      ctl_c_in.face  = face_b_ff;
      ctl_c_in.zero  = (m_b_ff == '0);
   end

   // valid bits and sideband
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         ctl_c_ff   <= '0;
      end else begin
         valid_a_ff <= up_valid;
         valid_b_ff <= valid_a_ff;
         ctl_c_ff   <= ctl_c_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      x_a_ff        <= up_dir_x;
      y_a_ff        <= up_dir_y;
      z_a_ff        <= up_dir_z;
      ax_a_ff       <= ax_a_in;
      ay_a_ff       <= ay_a_in;
      az_a_ff       <= az_a_in;
      face_b_ff     <= face_b_in;
      m_b_ff        <= m_b_in;
      nu_b_ff       <= nu_b_in;
      nv_b_ff       <= nv_b_in;
      denom_c_ff    <= denom_c_in;
      num_u_c_ff    <= num_u_c_in;
      num_v_c_ff    <= num_v_c_in;
      sat_u_c_ff    <= sat_u_c_in;
      sat_v_c_ff    <= sat_v_c_in;
   end

   assign dn_ctl   = ctl_c_ff;
   assign dn_denom = denom_c_ff;
   assign dn_num_u = num_u_c_ff;
   assign dn_num_v = num_v_c_ff;
   assign dn_sat_u = sat_u_c_ff;
   assign dn_sat_v = sat_v_c_ff;

endmodule

// ----- design/cmf_div_step.sv -----
`timescale 1ns / 1ps

module cmf_div_step #(
   parameter int DIR_BITS = 16,
   parameter int UV_BITS  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmf_pkg::cmf_ctl_type up_ctl,
   input  logic [DIR_BITS:0]    up_denom,
   input  logic [DIR_BITS:0]    up_rem_u,
   input  logic [DIR_BITS:0]    up_rem_v,
   input  logic [UV_BITS-1:0]   up_quo_u,
   input  logic [UV_BITS-1:0]   up_quo_v,
   input  logic                 up_sat_u,
   input  logic                 up_sat_v,
   output cmf_pkg::cmf_ctl_type dn_ctl,
   output logic [DIR_BITS:0]    dn_denom,
   output logic [DIR_BITS:0]    dn_rem_u,
   output logic [DIR_BITS:0]    dn_rem_v,
   output logic [UV_BITS-1:0]   dn_quo_u,
   output logic [UV_BITS-1:0]   dn_quo_v,
   output logic                 dn_sat_u,
   output logic                 dn_sat_v
);
   import cmf_pkg::*;

   cmf_ctl_type          ctl_ff;
   logic [DIR_BITS:0]    denom_ff;
   logic [DIR_BITS:0]    rem_u_ff, rem_u_in, rem_v_ff, rem_v_in;
   logic [UV_BITS-1:0]   quo_u_ff, quo_u_in, quo_v_ff, quo_v_in;
   logic                 sat_u_ff, sat_v_ff;

   logic [DIR_BITS+1:0]  shl_u, shl_v, dext, dif_u, dif_v;
   logic                 ge_u, ge_v;

   // one restoring step per lane: remainder stays below the divisor
   always_comb begin
      dext     = {1'b0, up_denom};
      shl_u    = {up_rem_u, 1'b0};
      shl_v    = {up_rem_v, 1'b0};
      ge_u     = (shl_u >= dext);
      ge_v     = (shl_v >= dext);
      dif_u    = ge_u ? (shl_u - dext) : shl_u;
      dif_v    = ge_v ? (shl_v - dext) : shl_v;
      rem_u_in = dif_u[DIR_BITS:0];
      rem_v_in = dif_v[DIR_BITS:0];
      quo_u_in = {up_quo_u[UV_BITS-2:0], ge_u};
      quo_v_in = {up_quo_v[UV_BITS-2:0], ge_v};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      denom_ff <= up_denom;
      rem_u_ff <= rem_u_in;
      rem_v_ff <= rem_v_in;
      quo_u_ff <= quo_u_in;
      quo_v_ff <= quo_v_in;
      sat_u_ff <= up_sat_u;
      sat_v_ff <= up_sat_v;
   end

   assign dn_ctl   = ctl_ff;
   assign dn_denom = denom_ff;
   assign dn_rem_u = rem_u_ff;
   assign dn_rem_v = rem_v_ff;
   assign dn_quo_u = quo_u_ff;
   assign dn_quo_v = quo_v_ff;
   assign dn_sat_u = sat_u_ff;
   assign dn_sat_v = sat_v_ff;

endmodule

// ----- design/cube_map_face_uv_select_core.sv -----
`timescale 1ns / 1ps

// Cube map face select with face coordinates.
// Request: pulse start with req_dir_x/y/z (signed). busy is always low, so a
// request may be issued on every clock; one request per cycle is sustained.
// Response: rsp_valid strobes for one cycle with rsp_face (0 +x .. 5 -z),
// rsp_tex_u/rsp_tex_v (unsigned Q0.UV_BITS, saturated below one) and
// rsp_map_present (face has a bound texture).
// Pipeline: three stages of magnitude, axis select and numerator setup, one
// stage per quotient bit in two parallel restoring dividers, and one output
// register.
// The receiver cannot stall; each response is offered exactly once.
// csr_write_en/csr_write_data write the six face-present bits; write only
// while no request is in flight.
// Reset (synchronous) clears the face-present bits and every valid bit in
// the pipe; requests in flight are dropped.
module cube_map_face_uv_select_core #(
   parameter int DIR_BITS = 16,
   parameter int UV_BITS  = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [DIR_BITS-1:0] req_dir_x,
   input  logic signed [DIR_BITS-1:0] req_dir_y,
   input  logic signed [DIR_BITS-1:0] req_dir_z,
   input  logic                       csr_write_en,
   input  logic [5:0]                 csr_write_data,
   output logic                       rsp_valid,
   output logic [2:0]                 rsp_face,
   output logic [UV_BITS-1:0]         rsp_tex_u,
   output logic [UV_BITS-1:0]         rsp_tex_v,
   output logic                       rsp_map_present
);
   import cmf_pkg::*;

   localparam logic [UV_BITS-1:0] UV_CENTER = {1'b1, {(UV_BITS-1){1'b0}}};
   localparam logic [UV_BITS-1:0] UV_MAX    = {UV_BITS{1'b1}};

   logic [FACE_COUNT-1:0] face_map_present_ff;

   // divider chain, entry 0 is the front end output
   cmf_ctl_type         ctl_s   [UV_BITS+1];
   logic [DIR_BITS:0]   denom_s [UV_BITS+1];
   logic [DIR_BITS:0]   rem_u_s [UV_BITS+1];
   logic [DIR_BITS:0]   rem_v_s [UV_BITS+1];
   logic [UV_BITS-1:0]  quo_u_s [UV_BITS+1];
   logic [UV_BITS-1:0]  quo_v_s [UV_BITS+1];
   logic                sat_u_s [UV_BITS+1];
   logic                sat_v_s [UV_BITS+1];

   logic                rsp_valid_ff;
   logic [2:0]          rsp_face_ff;
   logic [UV_BITS-1:0]  rsp_tex_u_ff, rsp_tex_u_in, rsp_tex_v_ff, rsp_tex_v_in;
   logic                rsp_map_present_ff, rsp_map_present_in;

   cmf_ctl_type         ctl_end;

   // pipe never holds a request off
   assign busy = 1'b0;

   // face-present register
   always_ff @(posedge clock) begin
      if (reset) begin
         face_map_present_ff <= '0;
      end else if (csr_write_en) begin
         face_map_present_ff <= csr_write_data;
      end
   end

   cmf_face_sel #(
      .DIR_BITS (DIR_BITS)
   ) u_face_sel (
      .clock    (clock),
      .reset    (reset),
      .up_valid (start && !busy),
      .up_dir_x (req_dir_x),
      .up_dir_y (req_dir_y),
      .up_dir_z (req_dir_z),
      .dn_ctl   (ctl_s[0]),
      .dn_denom (denom_s[0]),
      .dn_num_u (rem_u_s[0]),
      .dn_num_v (rem_v_s[0]),
      .dn_sat_u (sat_u_s[0]),
      .dn_sat_v (sat_v_s[0])
   );

   assign quo_u_s[0] = '0;
   assign quo_v_s[0] = '0;

   // one quotient bit per stage
   for (genvar i = 0; i < UV_BITS; i++) begin : g_div
      cmf_div_step #(
         .DIR_BITS (DIR_BITS),
         .UV_BITS  (UV_BITS)
      ) u_div_step (
         .clock    (clock),
         .reset    (reset),
         .up_ctl   (ctl_s[i]),
         .up_denom (denom_s[i]),
         .up_rem_u (rem_u_s[i]),
         .up_rem_v (rem_v_s[i]),
         .up_quo_u (quo_u_s[i]),
         .up_quo_v (quo_v_s[i]),
         .up_sat_u (sat_u_s[i]),
         .up_sat_v (sat_v_s[i]),
         .dn_ctl   (ctl_s[i+1]),
         .dn_denom (denom_s[i+1]),
         .dn_rem_u (rem_u_s[i+1]),
         .dn_rem_v (rem_v_s[i+1]),
         .dn_quo_u (quo_u_s[i+1]),
         .dn_quo_v (quo_v_s[i+1]),
         .dn_sat_u (sat_u_s[i+1]),
         .dn_sat_v (sat_v_s[i+1])
      );
   end

   // final select: zero vector gives the centre, n == m saturates
   always_comb begin
      ctl_end = ctl_s[UV_BITS];
      if (ctl_end.zero) begin
         rsp_tex_u_in = UV_CENTER;
         rsp_tex_v_in = UV_CENTER;
      end else begin
         rsp_tex_u_in = sat_u_s[UV_BITS] ? UV_MAX : quo_u_s[UV_BITS];
         rsp_tex_v_in = sat_v_s[UV_BITS] ? UV_MAX : quo_v_s[UV_BITS];
      end
      case (ctl_end.face)
         FACE_POS_X: rsp_map_present_in = face_map_present_ff[0];
         FACE_NEG_X: rsp_map_present_in = face_map_present_ff[1];
         FACE_POS_Y: rsp_map_present_in = face_map_present_ff[2];
         FACE_NEG_Y: rsp_map_present_in = face_map_present_ff[3];
         FACE_POS_Z: rsp_map_present_in = face_map_present_ff[4];
         FACE_NEG_Z: rsp_map_present_in = face_map_present_ff[5];
         default:    rsp_map_present_in = 1'b0;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl_end.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_face_ff        <= ctl_end.face;
      rsp_tex_u_ff       <= rsp_tex_u_in;
      rsp_tex_v_ff       <= rsp_tex_v_in;
      rsp_map_present_ff <= rsp_map_present_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_face        = rsp_face_ff;
   assign rsp_tex_u       = rsp_tex_u_ff;
   assign rsp_tex_v       = rsp_tex_v_ff;
   assign rsp_map_present = rsp_map_present_ff;

endmodule
